// ===== rtl/pba_pkg.sv =====
`default_nettype none

package pba_pkg;

  localparam int unsigned OFF_W      = 21;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned ALIGN_W    = 13;
  localparam int unsigned TOTAL_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [OFF_W-1:0] CAP_RESET = OFF_W'(1048576);

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RESET   = 2'd1,
    REQ_RESTORE = 2'd2,
    REQ_SWAP    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_NOMEM   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_A = 2'd0,
    CFG_CAP_A  = 2'd1,
    CFG_BASE_B = 2'd2,
    CFG_CAP_B  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    req_e               req_type;
    logic               arena_side;
    logic [OFF_W-1:0]   alloc_size;
    logic [ALIGN_W-1:0] alignment;
    logic [OFF_W-1:0]   restore_mark;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic                granted;
    logic [ADDR_W-1:0]   address_out;
    logic [OFF_W-1:0]    offset_out;
    logic [OFF_W-1:0]    used_bytes;
    logic [OFF_W-1:0]    remaining_bytes;
    logic [OFF_W-1:0]    peak_bytes;
    logic [TOTAL_W-1:0]  alloc_total;
    logic                active_role;
  } rsp_t;

  typedef struct packed {
    status_e           status;
    logic              granted;
    logic [ADDR_W-1:0] address;
    logic [OFF_W-1:0]  offset;
    logic [OFF_W-1:0]  remaining;
  } grant_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_a;
    logic [OFF_W-1:0]  cap_a;
    logic [ADDR_W-1:0] base_b;
    logic [OFF_W-1:0]  cap_b;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/pba_req_if.sv =====
`default_nettype none

interface pba_req_if;
  logic          valid;
  logic          ready;
  pba_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pba_rsp_if.sv =====
`default_nettype none

interface pba_rsp_if;
  logic          valid;
  logic          ready;
  pba_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pingpong_bump_allocator.sv =====
// Ping-pong pair of bump arenas, A and B, each with an offset, a lifetime peak
// and a saturating allocation count. Each request beat on req_i carries one of
// alloc, reset, restore or swap and returns exactly one response beat on rsp_o
// describing the selected arena (arena_side picks the input or output role,
// resolved after any swap). A request is registered on entry, evaluated by
// combinational align, compare and update logic against the arena registers,
// and the response is registered on exit; a new request is taken every cycle
// while the response side keeps up. Capacities above 2^OFFSET_BITS are clamped
// to it. The user must write base and capacity registers (cfg_we_i/cfg_idx_i/
// cfg_data_i) only while no request is in flight; the block does not check it.
`default_nettype none

module pingpong_bump_allocator #(
  parameter int unsigned OFFSET_BITS = 20,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pba_req_if.sink                             req_i,
  pba_rsp_if.source                           rsp_o
);
  import pba_pkg::*;

  localparam int unsigned CNT_EXT_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

  cfg_t cfg;

  logic in_vld_q;
  req_t in_q;
  logic out_vld_q;
  rsp_t rsp_q;
  rsp_t rsp_d;
  logic advance;
  logic in_take;

  logic                  role_q, role_d;
  logic [OFF_W-1:0]      off_a_q, off_b_q, off_a_d, off_b_d;
  logic [OFF_W-1:0]      peak_a_q, peak_b_q, peak_a_d, peak_b_d;
  logic [COUNT_BITS-1:0] cnt_a_q, cnt_b_q, cnt_a_d, cnt_b_d;

  logic                  swap;
  logic                  sel_b;
  logic [OFF_W-1:0]      off_a_pre, off_b_pre;
  logic [COUNT_BITS-1:0] cnt_a_pre, cnt_b_pre;
  logic [OFF_W-1:0]      off_sel, peak_sel, cap_sel;
  logic [COUNT_BITS-1:0] cnt_sel;
  logic [ADDR_W-1:0]     base_sel;
  logic [OFF_W-1:0]      off_new, peak_new;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [CNT_EXT_W-1:0]  cnt_ext;
  grant_t                grant;

  pba_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign in_take     = req_i.valid && req_i.ready;

  // clear the old input arena before the roles flip
  always_comb begin
    swap      = (in_q.req_type == REQ_SWAP);
    off_a_pre = (swap && !role_q) ? '0 : off_a_q;
    cnt_a_pre = (swap && !role_q) ? '0 : cnt_a_q;
    off_b_pre = (swap && role_q) ? '0 : off_b_q;
    cnt_b_pre = (swap && role_q) ? '0 : cnt_b_q;
    role_d    = role_q ^ swap;
    sel_b     = role_d ^ in_q.arena_side;

    off_sel  = sel_b ? off_b_pre : off_a_pre;
    cnt_sel  = sel_b ? cnt_b_pre : cnt_a_pre;
    peak_sel = sel_b ? peak_b_q : peak_a_q;
    cap_sel  = sel_b ? cfg.cap_b : cfg.cap_a;
    base_sel = sel_b ? cfg.base_b : cfg.base_a;
  end

  pba_alloc_unit #(
    .OFFSET_BITS (OFFSET_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_alloc (
    .req_i   (in_q),
    .off_i   (off_sel),
    .peak_i  (peak_sel),
    .cnt_i   (cnt_sel),
    .cap_i   (cap_sel),
    .base_i  (base_sel),
    .off_o   (off_new),
    .peak_o  (peak_new),
    .cnt_o   (cnt_new),
    .grant_o (grant)
  );

  always_comb begin
    off_a_d  = sel_b ? off_a_pre : off_new;
    cnt_a_d  = sel_b ? cnt_a_pre : cnt_new;
    peak_a_d = sel_b ? peak_a_q : peak_new;
    off_b_d  = sel_b ? off_new : off_b_pre;
    cnt_b_d  = sel_b ? cnt_new : cnt_b_pre;
    peak_b_d = sel_b ? peak_new : peak_b_q;

    cnt_ext               = CNT_EXT_W'(cnt_new);
    rsp_d.status          = grant.status;
    rsp_d.granted         = grant.granted;
    rsp_d.address_out     = grant.address;
    rsp_d.offset_out      = grant.offset;
    rsp_d.used_bytes      = off_new;
    rsp_d.remaining_bytes = grant.remaining;
    rsp_d.peak_bytes      = peak_new;
    rsp_d.alloc_total     = cnt_ext[TOTAL_W-1:0];
    rsp_d.active_role     = role_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      role_q    <= 1'b0;
      off_a_q   <= '0;
      off_b_q   <= '0;
      peak_a_q  <= '0;
      peak_b_q  <= '0;
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        role_q    <= role_d;
        off_a_q   <= off_a_d;
        off_b_q   <= off_b_d;
        peak_a_q  <= peak_a_d;
        peak_b_q  <= peak_b_d;
        cnt_a_q   <= cnt_a_d;
        cnt_b_q   <= cnt_b_d;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // hold payloads until the next beat
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= req_i.data;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/pba_cfg_regs.sv =====
`default_nettype none

module pba_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [pba_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output pba_pkg::cfg_t                           cfg_o
);
  import pba_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_a <= '0;
      cfg_q.cap_a  <= CAP_RESET;
      cfg_q.base_b <= '0;
      cfg_q.cap_b  <= CAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_A: cfg_q.base_a <= cfg_data_i[ADDR_W-1:0];
        CFG_CAP_A:  cfg_q.cap_a  <= cfg_data_i[OFF_W-1:0];
        CFG_BASE_B: cfg_q.base_b <= cfg_data_i[ADDR_W-1:0];
        CFG_CAP_B:  cfg_q.cap_b  <= cfg_data_i[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/pba_alloc_unit.sv =====
`default_nettype none

module pba_alloc_unit #(
  parameter int unsigned OFFSET_BITS = 20,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire pba_pkg::req_t                  req_i,
  input  wire logic [pba_pkg::OFF_W-1:0]      off_i,
  input  wire logic [pba_pkg::OFF_W-1:0]      peak_i,
  input  wire logic [COUNT_BITS-1:0]          cnt_i,
  input  wire logic [pba_pkg::OFF_W-1:0]      cap_i,
  input  wire logic [pba_pkg::ADDR_W-1:0]     base_i,
  output logic [pba_pkg::OFF_W-1:0]           off_o,
  output logic [pba_pkg::OFF_W-1:0]           peak_o,
  output logic [COUNT_BITS-1:0]               cnt_o,
  output pba_pkg::grant_t                     grant_o
);
  import pba_pkg::*;

  localparam int unsigned SUM_W = OFF_W + 2;
  localparam logic [32:0] CAP_LIM = 33'(1) << OFFSET_BITS;

  logic [OFF_W-1:0]   cap_eff;
  logic [ALIGN_W-1:0] align_m1;
  logic               align_ok;
  logic [SUM_W-1:0]   aligned;
  logic [SUM_W-1:0]   end_off;
  logic               fits;
  logic [OFF_W-1:0]   off_n;

  always_comb begin
    cap_eff  = (33'(cap_i) > CAP_LIM) ? CAP_LIM[OFF_W-1:0] : cap_i;
    align_m1 = req_i.alignment - ALIGN_W'(1);
    align_ok = (req_i.alignment != '0) && ((req_i.alignment & align_m1) == '0);
    aligned  = (SUM_W'(off_i) + SUM_W'(align_m1)) & ~SUM_W'(align_m1);
    end_off  = aligned + SUM_W'(req_i.alloc_size);
    fits     = end_off <= SUM_W'(cap_eff);

    off_n            = off_i;
    peak_o           = peak_i;
    cnt_o            = cnt_i;
    grant_o.status   = STATUS_OK;
    grant_o.granted  = 1'b0;
    grant_o.address  = '0;
    grant_o.offset   = '0;

    case (req_i.req_type)
      REQ_ALLOC: begin
        if (req_i.alloc_size != '0) begin
          if (!align_ok) begin
            grant_o.status = STATUS_INVALID;
          end else if (!fits) begin
            grant_o.status = STATUS_NOMEM;
          end else begin
            grant_o.granted = 1'b1;
            grant_o.offset  = aligned[OFF_W-1:0];
            grant_o.address = base_i + ADDR_W'(aligned);
            off_n           = end_off[OFF_W-1:0];
            if (cnt_i != '1) begin
              cnt_o = cnt_i + COUNT_BITS'(1);
            end
            if (end_off[OFF_W-1:0] > peak_i) begin
              peak_o = end_off[OFF_W-1:0];
            end
          end
        end
      end
      REQ_RESET: begin
        off_n = '0;
        cnt_o = '0;
      end
      REQ_RESTORE: begin
        if (req_i.restore_mark <= off_i) begin
          off_n = req_i.restore_mark;
        end
      end
      default: ;
    endcase

    off_o             = off_n;
    grant_o.remaining = (cap_eff > off_n) ? cap_eff - off_n : '0;
  end

endmodule

`default_nettype wire
